>>> src/three_phase_sine_pwm_compare_macros.svh
// Assertion macros shared by the three-phase sine PWM compare block.
// Included by the RTL files that carry assertions; depends on nothing else.
`ifndef THREE_PHASE_SINE_PWM_COMPARE_MACROS_SVH
`define THREE_PHASE_SINE_PWM_COMPARE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define SPWM_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Implication with a fixed cycle delay between cause and effect.
`define SPWM_ASSERT_DELAY(lbl, ck, rn, ante, n, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##(n) (cons)) \
        else $error(msg);
`else
`define SPWM_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define SPWM_ASSERT_DELAY(lbl, ck, rn, ante, n, cons, msg)
`endif
`endif

>>> src/spwm_pkg.sv
`timescale 1ns / 1ps
// Package for the three-phase sine PWM compare block: widths, constants,
// the CORDIC word type, the arctangent table and the Q1.15 rounding helper.
// No dependencies.
package spwm_pkg;

    // Phase and trig precision.
    localparam int PHASE_BITS   = 16;
    localparam int TRIG_BITS    = 16;
    localparam int CORDIC_ITERS = (TRIG_BITS < 24) ? TRIG_BITS : 24;
    localparam int ITER_W       = 5;

    // Field and datapath widths.
    localparam int COUNT_W = 32;
    localparam int STEP_W  = 32;
    localparam int AMP_W   = 16;
    localparam int INDEX_W = 16;
    localparam int Q15_W   = 16;
    localparam int CMP_W   = 15;
    localparam int XY_W    = TRIG_BITS + 3;
    localparam int Z_W     = 32;
    localparam int WAVE_W  = 33;
    localparam int PROD_W  = 50;
    localparam int TOTAL_W = 51;
    localparam int LEVEL_W = 34;
    localparam int SCALE_W = 50;

    // APB register map.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [1:0] REG_PHASE_STEP        = 2'd0;
    localparam logic [1:0] REG_CARRIER_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_MODULATION_INDEX  = 2'd2;

    // Quadrant codes taken from the top two phase bits.
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // Cycles from an accepted start to the done strobe being seen.
    localparam int LATENCY = CORDIC_ITERS + 7;

    // CORDIC start vector, 1/gain at TRIG_BITS fraction bits.
    localparam logic [XY_W-1:0] CORDIC_X0 =
        XY_W'((64'd652032874 + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS));

    // sqrt(3)/2 scaled by 2^16.
    localparam logic signed [WAVE_W-1:0] SQRT3_HALF = 33'sd56756;

    // Offset of 1.0 in the level sum, units of 2^-46.
    localparam logic signed [TOTAL_W-1:0] LEVEL_ONE = 51'sd1 <<< 46;

    // Q1.15 conversion shifts.
    localparam int Q15_DN = (TRIG_BITS > 15) ? (TRIG_BITS - 15) : 0;
    localparam int Q15_UP = (TRIG_BITS < 15) ? (15 - TRIG_BITS) : 0;
    localparam logic signed [39:0] Q15_RND = (40'sd1 <<< Q15_DN) >>> 1;

    typedef struct packed {
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_word_t;

    // Arctangent of 2^-i in turns scaled by 2^32.
    function automatic logic [Z_W-1:0] atan_turns(input logic [ITER_W-1:0] idx);
        logic [Z_W-1:0] a;
        unique case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2E;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round half up to Q1.15 and saturate to the signed 16-bit range.
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [39:0] w;
        logic signed [39:0] r;
        w = 40'(v);
        r = ((w + Q15_RND) >>> Q15_DN) <<< Q15_UP;
        if (r > 40'sd32767) begin
            r = 40'sd32767;
        end
        else if (r < -40'sd32768) begin
            r = -40'sd32768;
        end
        return Q15_W'(r);
    endfunction

endpackage

>>> src/spwm_cordic_cell.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on spwm_pkg for the word type and the arctangent table.
module spwm_cordic_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [spwm_pkg::ITER_W-1:0] iter,
    input  spwm_pkg::cordic_word_t      word_in,
    input  logic                        valid_in,
    output spwm_pkg::cordic_word_t      word_out,
    output logic                        valid_out
);

    spwm_pkg::cordic_word_t                word_reg;
    spwm_pkg::cordic_word_t                word_next;
    logic                                  vld_reg;
    logic                                  vld_next;
    logic signed [spwm_pkg::XY_W-1:0]      dx;
    logic signed [spwm_pkg::XY_W-1:0]      dy;
    logic signed [spwm_pkg::Z_W-1:0]       ang;

    // Rotate toward zero residual angle; shifts floor toward minus infinity.
    always_comb
    begin
        dx  = word_in.y >>> iter;
        dy  = word_in.x >>> iter;
        ang = $signed(spwm_pkg::atan_turns(iter));
        word_next.quad = word_in.quad;
        if (!word_in.z[spwm_pkg::Z_W-1])
        begin
            word_next.x = word_in.x - dx;
            word_next.y = word_in.y + dy;
            word_next.z = word_in.z - ang;
        end
        else
        begin
            word_next.x = word_in.x + dx;
            word_next.y = word_in.y - dy;
            word_next.z = word_in.z + ang;
        end
        vld_next = valid_in;
    end

    // Valid flag is control state; the word itself needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out  = word_reg;
    assign valid_out = vld_reg;

endmodule

>>> src/spwm_compare_lane.sv
`timescale 1ns / 1ps
// One compare lane: scales a phase wave by depth and carrier amplitude
// in three registered steps. Depends on spwm_pkg for widths.
module spwm_compare_lane
(
    input  logic                                clk,
    input  logic signed [spwm_pkg::WAVE_W-1:0]  wave,
    input  logic [spwm_pkg::INDEX_W-1:0]        index,
    input  logic [spwm_pkg::AMP_W-1:0]          amplitude,
    output logic [spwm_pkg::CMP_W-1:0]          compare
);

    logic signed [spwm_pkg::PROD_W-1:0]  prod_reg;
    logic signed [spwm_pkg::PROD_W-1:0]  prod_next;
    logic [spwm_pkg::LEVEL_W-1:0]        level_reg;
    logic [spwm_pkg::LEVEL_W-1:0]        level_next;
    logic [spwm_pkg::CMP_W-1:0]          cmp_reg;
    logic [spwm_pkg::CMP_W-1:0]          cmp_next;
    logic signed [spwm_pkg::TOTAL_W-1:0] total;
    logic [spwm_pkg::SCALE_W-1:0]        scaled;
    logic [spwm_pkg::SCALE_W-33:0]       counts;

    // Depth times wave, units of 2^-46.
    assign prod_next = spwm_pkg::PROD_W'($signed({1'b0, index}))
                     * spwm_pkg::PROD_W'(wave);

    // Add 1.0, clamp negative levels to zero and round half up to units of 2^-30.
    always_comb
    begin
        total = spwm_pkg::TOTAL_W'(prod_reg) + spwm_pkg::LEVEL_ONE;
        if (total[spwm_pkg::TOTAL_W-1])
        begin
            total = '0;
        end
        level_next = spwm_pkg::LEVEL_W'((total + spwm_pkg::TOTAL_W'(32768)) >>> 16);
    end

    // Scale by the carrier amplitude and saturate to the compare range.
    always_comb
    begin
        scaled = spwm_pkg::SCALE_W'(amplitude) * spwm_pkg::SCALE_W'(level_reg);
        counts = scaled[spwm_pkg::SCALE_W-1:32];
        if (counts > (spwm_pkg::SCALE_W-32)'(32767))
        begin
            cmp_next = '1;
        end
        else
        begin
            cmp_next = counts[spwm_pkg::CMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        level_reg <= level_next;
        cmp_reg   <= cmp_next;
    end

    assign compare = cmp_reg;

endmodule

>>> src/three_phase_sine_pwm_compare.sv
`timescale 1ns / 1ps
// Top level of the three-phase sine PWM compare block: APB registers, phase
// multiplier, CORDIC cell chain, wave forming and three compare lanes.
// Depends on spwm_pkg, spwm_cordic_cell, spwm_compare_lane and the macro header.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------------
//  input     start, busy            sample_count
//  result    done (one-cycle pulse) compare_phase_a/b/c, sine_value, cosine_value
//  config    APB psel/penable/...   phase_step, carrier_amplitude, modulation_index
//
// A new word is taken in every clock cycle; busy is always low.
// Each word's result is registered through the phase stage, the chain of one CORDIC
// cell per iteration and the rounding, wave and compare-lane stages after it.
// Reset clears the configuration registers and the valid flags; no memory needs a clearing pass.
// The receiver cannot stall, so the pipeline never holds.

`include "three_phase_sine_pwm_compare_macros.svh"

module three_phase_sine_pwm_compare
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [spwm_pkg::COUNT_W-1:0]         sample_count,
    output logic                                 done,
    output logic [spwm_pkg::CMP_W-1:0]           compare_phase_a,
    output logic [spwm_pkg::CMP_W-1:0]           compare_phase_b,
    output logic [spwm_pkg::CMP_W-1:0]           compare_phase_c,
    output logic signed [spwm_pkg::Q15_W-1:0]    sine_value,
    output logic signed [spwm_pkg::Q15_W-1:0]    cosine_value,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spwm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [spwm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int N = spwm_pkg::CORDIC_ITERS;
    localparam int PB = spwm_pkg::PHASE_BITS;

    // Configuration registers.
    logic [spwm_pkg::STEP_W-1:0]  phase_step_reg;
    logic [spwm_pkg::STEP_W-1:0]  phase_step_next;
    logic [spwm_pkg::AMP_W-1:0]   carrier_amplitude_reg;
    logic [spwm_pkg::AMP_W-1:0]   carrier_amplitude_next;
    logic [spwm_pkg::INDEX_W-1:0] modulation_index_reg;
    logic [spwm_pkg::INDEX_W-1:0] modulation_index_next;
    logic                         cfg_write;

    // Phase stage.
    logic                         accept;
    logic [spwm_pkg::STEP_W-1:0]  phase_prod;
    logic [PB-1:0]                phase_reg;
    logic [PB-1:0]                phase_next;
    logic                         phase_vld_reg;

    // CORDIC chain.
    spwm_pkg::cordic_word_t       chain_word [0:N];
    logic                         chain_vld  [0:N];

    // Post-CORDIC stages.
    logic signed [spwm_pkg::XY_W-1:0]   s_raw;
    logic signed [spwm_pkg::XY_W-1:0]   c_raw;
    logic signed [spwm_pkg::Q15_W-1:0]  sn_q_reg;
    logic signed [spwm_pkg::Q15_W-1:0]  cs_q_reg;
    logic signed [spwm_pkg::Q15_W-1:0]  sn_q_next;
    logic signed [spwm_pkg::Q15_W-1:0]  cs_q_next;
    logic signed [spwm_pkg::Q15_W-1:0]  sn_w1_reg;
    logic signed [spwm_pkg::WAVE_W-1:0] csk_w1_reg;
    logic signed [spwm_pkg::WAVE_W-1:0] csk_w1_next;
    logic signed [spwm_pkg::WAVE_W-1:0] half_sn;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_a_reg;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_b_reg;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_c_reg;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_a_next;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_b_next;
    logic signed [spwm_pkg::WAVE_W-1:0] wave_c_next;
    logic signed [spwm_pkg::Q15_W-1:0]  cs_w1_reg;
    logic signed [spwm_pkg::Q15_W-1:0]  sn_d_reg [0:3];
    logic signed [spwm_pkg::Q15_W-1:0]  cs_d_reg [0:3];
    logic [5:0]                         post_vld_reg;
    logic [5:0]                         post_vld_next;

    // The pipeline never stalls, so it is always ready.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Register writes on the APB access phase.
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        phase_step_next        = phase_step_reg;
        carrier_amplitude_next = carrier_amplitude_reg;
        modulation_index_next  = modulation_index_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                spwm_pkg::REG_PHASE_STEP:
                    phase_step_next = pwdata;
                spwm_pkg::REG_CARRIER_AMPLITUDE:
                    carrier_amplitude_next = pwdata[spwm_pkg::AMP_W-1:0];
                spwm_pkg::REG_MODULATION_INDEX:
                    modulation_index_next = pwdata[spwm_pkg::INDEX_W-1:0];
                default:
                    phase_step_next = phase_step_reg;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            spwm_pkg::REG_PHASE_STEP:
                prdata = phase_step_reg;
            spwm_pkg::REG_CARRIER_AMPLITUDE:
                prdata = spwm_pkg::CFG_DATA_W'(carrier_amplitude_reg);
            spwm_pkg::REG_MODULATION_INDEX:
                prdata = spwm_pkg::CFG_DATA_W'(modulation_index_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg        <= '0;
            carrier_amplitude_reg <= '0;
            modulation_index_reg  <= '0;
        end
        else
        begin
            phase_step_reg        <= phase_step_next;
            carrier_amplitude_reg <= carrier_amplitude_next;
            modulation_index_reg  <= modulation_index_next;
        end
    end

    // Phase is step times count modulo one turn; only the top bits are kept.
    assign phase_prod = phase_step_reg * sample_count;
    assign phase_next = phase_prod[spwm_pkg::STEP_W-1 -: PB];

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
    end

    // Seed word for the first cell: quadrant plus the angle inside it.
    always_comb
    begin
        chain_word[0].quad = phase_reg[PB-1:PB-2];
        chain_word[0].x    = spwm_pkg::CORDIC_X0;
        chain_word[0].y    = '0;
        chain_word[0].z    = $signed({2'b00, phase_reg[PB-3:0], {(32 - PB){1'b0}}});
        chain_vld[0]       = phase_vld_reg;
    end

    // One CORDIC cell per iteration.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        spwm_cordic_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .iter      (spwm_pkg::ITER_W'(i)),
            .word_in   (chain_word[i]),
            .valid_in  (chain_vld[i]),
            .word_out  (chain_word[i+1]),
            .valid_out (chain_vld[i+1])
        );
    end

    // Map the first-quadrant result back to the full circle and round to Q1.15.
    always_comb
    begin
        unique case (chain_word[N].quad)
            spwm_pkg::QUAD_I:
            begin
                s_raw = chain_word[N].y;
                c_raw = chain_word[N].x;
            end
            spwm_pkg::QUAD_II:
            begin
                s_raw = chain_word[N].x;
                c_raw = -chain_word[N].y;
            end
            spwm_pkg::QUAD_III:
            begin
                s_raw = -chain_word[N].y;
                c_raw = -chain_word[N].x;
            end
            default:
            begin
                s_raw = -chain_word[N].x;
                c_raw = chain_word[N].y;
            end
        endcase
        sn_q_next = spwm_pkg::to_q15(s_raw);
        cs_q_next = spwm_pkg::to_q15(c_raw);
    end

    // Cosine times sqrt(3)/2, then the three phase waves in units of 2^-31.
    assign csk_w1_next = spwm_pkg::WAVE_W'(cs_q_reg) * spwm_pkg::SQRT3_HALF;
    assign half_sn     = spwm_pkg::WAVE_W'(sn_w1_reg) <<< 15;
    assign wave_a_next = spwm_pkg::WAVE_W'(sn_w1_reg) <<< 16;
    assign wave_b_next = -half_sn - csk_w1_reg;
    assign wave_c_next = -half_sn + csk_w1_reg;

    always_ff @(posedge clk)
    begin
        sn_q_reg    <= sn_q_next;
        cs_q_reg    <= cs_q_next;
        sn_w1_reg   <= sn_q_reg;
        cs_w1_reg   <= cs_q_reg;
        csk_w1_reg  <= csk_w1_next;
        wave_a_reg  <= wave_a_next;
        wave_b_reg  <= wave_b_next;
        wave_c_reg  <= wave_c_next;
        sn_d_reg[0] <= sn_w1_reg;
        cs_d_reg[0] <= cs_w1_reg;
        sn_d_reg[1] <= sn_d_reg[0];
        cs_d_reg[1] <= cs_d_reg[0];
        sn_d_reg[2] <= sn_d_reg[1];
        cs_d_reg[2] <= cs_d_reg[1];
        sn_d_reg[3] <= sn_d_reg[2];
        cs_d_reg[3] <= cs_d_reg[2];
    end

    // Three compare lanes, one per phase.
    spwm_compare_lane u_lane_a
    (
        .clk       (clk),
        .wave      (wave_a_reg),
        .index     (modulation_index_reg),
        .amplitude (carrier_amplitude_reg),
        .compare   (compare_phase_a)
    );

    spwm_compare_lane u_lane_b
    (
        .clk       (clk),
        .wave      (wave_b_reg),
        .index     (modulation_index_reg),
        .amplitude (carrier_amplitude_reg),
        .compare   (compare_phase_b)
    );

    spwm_compare_lane u_lane_c
    (
        .clk       (clk),
        .wave      (wave_c_reg),
        .index     (modulation_index_reg),
        .amplitude (carrier_amplitude_reg),
        .compare   (compare_phase_c)
    );

    // Valid flags for the stages after the CORDIC chain.
    assign post_vld_next = {post_vld_reg[4:0], chain_vld[N]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg <= 1'b0;
            post_vld_reg  <= '0;
        end
        else
        begin
            phase_vld_reg <= accept;
            post_vld_reg  <= post_vld_next;
        end
    end

    assign done         = post_vld_reg[5];
    assign sine_value   = sn_d_reg[3];
    assign cosine_value = cs_d_reg[3];

    // Every accepted word comes out exactly once, a fixed latency later.
    `SPWM_ASSERT_DELAY(a_latency, clk, rst_n, accept, spwm_pkg::LATENCY, done, "result strobe missing after accepted word")
    `SPWM_ASSERT_IMPL(a_no_phantom, clk, rst_n, done, $past(accept, spwm_pkg::LATENCY), "result strobe without an accepted word")
    // A zero amplitude in the last lane step forces all compare values to zero.
    `SPWM_ASSERT_IMPL(a_zero_amp, clk, rst_n, done && ($past(carrier_amplitude_reg) == 16'd0), (compare_phase_a == 15'd0) && (compare_phase_b == 15'd0) && (compare_phase_c == 15'd0), "nonzero compare with zero amplitude")

endmodule
